// File: sv/dbms_pkg.sv
// Package for the debounced button mode selector: widths, button and
// register codes, reset values, config and mode state types.
// No dependencies.
package dbms_pkg;

  // Number of measurement types the menu cycles through (2 to 8)
  localparam int NumTypes   = 5;
  localparam int TypeW      = 3;
  localparam int CodeW      = 3;
  localparam int RangeW     = 3;
  localparam int CountW     = 4;
  localparam int CfgW       = 3;
  localparam int CfgIdxW    = 3;
  localparam int NumMaxRegs = 5;

  typedef logic [CodeW-1:0]   code_t;
  typedef logic [TypeW-1:0]   type_t;
  typedef logic [RangeW-1:0]  range_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgW-1:0]    cfg_data_t;

  // Button codes
  localparam code_t BtnNone      = code_t'(0);
  localparam code_t BtnTypeUp    = code_t'(1);
  localparam code_t BtnTypeDown  = code_t'(2);
  localparam code_t BtnRangeUp   = code_t'(3);
  localparam code_t BtnRangeDown = code_t'(4);
  localparam code_t BtnAuto      = code_t'(5);
  localparam code_t BtnComms     = code_t'(6);

  // Config register indexes
  localparam cfg_idx_t RegDebounce       = cfg_idx_t'(0);
  localparam cfg_idx_t RegMaxVoltage     = cfg_idx_t'(1);
  localparam cfg_idx_t RegMaxCurrent     = cfg_idx_t'(2);
  localparam cfg_idx_t RegMaxResistance  = cfg_idx_t'(3);
  localparam cfg_idx_t RegMaxFrequency   = cfg_idx_t'(4);
  localparam cfg_idx_t RegMaxCapacitance = cfg_idx_t'(5);

  localparam cfg_data_t DebounceReset = cfg_data_t'(3);
  localparam range_t MaxVoltageReset     = range_t'(5);
  localparam range_t MaxCurrentReset     = range_t'(3);
  localparam range_t MaxResistanceReset  = range_t'(0);
  localparam range_t MaxFrequencyReset   = range_t'(0);
  localparam range_t MaxCapacitanceReset = range_t'(2);

  localparam type_t TypeTop = type_t'(NumTypes - 1);

  typedef struct packed {
    cfg_data_t                   debounce_ticks;
    range_t [NumMaxRegs-1:0]     max_range;     // [0] voltage .. [4] capacitance
  } cfg_t;

  typedef struct packed {
    type_t  type_sel;
    range_t range_sel;
    logic   auto_on;
    logic   comms_on;
  } mode_t;

  // Range maximum of a type; types with no register read as 0
  function automatic range_t range_max_of(cfg_t cfg, type_t t);
    range_t r;
    r = '0;
    for (int i = 0; i < NumMaxRegs; i++) begin
      if (t == type_t'(i)) r = cfg.max_range[i];
    end
    return r;
  endfunction

endpackage

// File: sv/dbms_sample_if.sv
// Input channel of the mode selector: one sampled button code per item.
// Depends on dbms_pkg.
interface dbms_sample_if;
  logic               valid;
  logic               ready;
  dbms_pkg::code_t    button_code;

  modport source(output valid, output button_code, input ready);
  modport sink(input valid, input button_code, output ready);
endinterface

// File: sv/dbms_result_if.sv
// Output channel of the mode selector: accepted press and mode state per item.
// Depends on dbms_pkg.
interface dbms_result_if;
  logic               valid;
  logic               ready;
  dbms_pkg::code_t    accepted_press;
  dbms_pkg::type_t    mode_type;
  dbms_pkg::range_t   range_select;
  logic               auto_range_on;
  logic               comms_on;

  modport source(output valid, output accepted_press, output mode_type,
                 output range_select, output auto_range_on, output comms_on,
                 input ready);
  modport sink(input valid, input accepted_press, input mode_type,
               input range_select, input auto_range_on, input comms_on,
               output ready);
endinterface

// File: sv/dbms_cfg_regs.sv
// Configuration register file: debounce length and per-type range maxima.
// Depends on dbms_pkg.
module dbms_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  dbms_pkg::cfg_idx_t    cfg_index,
  input  dbms_pkg::cfg_data_t   cfg_wdata,
  output dbms_pkg::cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= dbms_pkg::DebounceReset;
      cfg.max_range[0]   <= dbms_pkg::MaxVoltageReset;
      cfg.max_range[1]   <= dbms_pkg::MaxCurrentReset;
      cfg.max_range[2]   <= dbms_pkg::MaxResistanceReset;
      cfg.max_range[3]   <= dbms_pkg::MaxFrequencyReset;
      cfg.max_range[4]   <= dbms_pkg::MaxCapacitanceReset;
    end else if (cfg_we) begin
      case (cfg_index)
        dbms_pkg::RegDebounce:       cfg.debounce_ticks <= cfg_wdata;
        dbms_pkg::RegMaxVoltage:     cfg.max_range[0]   <= cfg_wdata;
        dbms_pkg::RegMaxCurrent:     cfg.max_range[1]   <= cfg_wdata;
        dbms_pkg::RegMaxResistance:  cfg.max_range[2]   <= cfg_wdata;
        dbms_pkg::RegMaxFrequency:   cfg.max_range[3]   <= cfg_wdata;
        dbms_pkg::RegMaxCapacitance: cfg.max_range[4]   <= cfg_wdata;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

endmodule

// File: sv/dbms_menu.sv
// Menu action logic: applies one accepted button code to the mode state.
// Depends on dbms_pkg.
module dbms_menu (
  input  dbms_pkg::code_t   code,
  input  dbms_pkg::mode_t   mode,
  input  dbms_pkg::cfg_t    cfg,
  output dbms_pkg::mode_t   mode_act,
  output dbms_pkg::code_t   acc
);

  dbms_pkg::range_t mx;

  assign mx = dbms_pkg::range_max_of(cfg, mode.type_sel);

  always_comb begin
    mode_act = mode;
    acc      = code;
    case (code)
      dbms_pkg::BtnTypeUp: begin
        mode_act.type_sel = (mode.type_sel >= dbms_pkg::TypeTop) ? '0
                          : dbms_pkg::type_t'(mode.type_sel + 1'b1);
      end
      dbms_pkg::BtnTypeDown: begin
        mode_act.type_sel = (mode.type_sel == '0 || mode.type_sel > dbms_pkg::TypeTop)
                          ? dbms_pkg::TypeTop
                          : dbms_pkg::type_t'(mode.type_sel - 1'b1);
      end
      dbms_pkg::BtnRangeUp: begin
        // index at or past the type's maximum wraps to zero
        if (!mode.auto_on)
          mode_act.range_sel = (mode.range_sel >= mx) ? '0
                             : dbms_pkg::range_t'(mode.range_sel + 1'b1);
      end
      dbms_pkg::BtnRangeDown: begin
        if (!mode.auto_on)
          mode_act.range_sel = (mode.range_sel == '0) ? mx
                             : dbms_pkg::range_t'(mode.range_sel - 1'b1);
      end
      dbms_pkg::BtnAuto:  mode_act.auto_on  = ~mode.auto_on;
      dbms_pkg::BtnComms: mode_act.comms_on = ~mode.comms_on;
      default:            acc = dbms_pkg::BtnNone;  // none, or unused code
    endcase
  end

endmodule

// File: sv/debounced_button_mode_selector.sv
// Top level of the debounced button mode selector: input stage, debounce
// counter, mode state and result register.
// Depends on dbms_pkg, dbms_sample_if, dbms_result_if, dbms_cfg_regs, dbms_menu.
//
// Usage:
//   sample  - one item per debounce tick carrying a button code (0 none,
//             1/2 type up/down, 3/4 range up/down, 5 auto toggle,
//             6 comms toggle). Taken when valid and ready are both high.
//   result  - exactly one item per sample: the press acted on (0 if none)
//             and the mode type, range index, auto and comms flags as
//             they stand after that sample.
//   cfg     - plain write port (cfg_we, cfg_index, cfg_wdata); index 0 is
//             the debounce length, 1..5 the range maxima per type. Write
//             only while no item is in flight.
// Path: a sample is held in the input register, then in the result register;
// a stall on result can hold it in either.
// Throughput: one item per cycle while result is taken; the single state
// update path between the input register and the result register sets this.
// Stall: if result is not taken, both stages hold, the state is frozen,
// and sample.ready drops once the input register is also full.
// Reset (rst, synchronous): both stages empty, mode state and debounce
// counter cleared, config registers back to their defaults.
module debounced_button_mode_selector (
  input  logic                 clk,
  input  logic                 rst,
  dbms_sample_if.sink          sample,
  dbms_result_if.source        result,
  input  logic                 cfg_we,
  input  dbms_pkg::cfg_idx_t   cfg_index,
  input  dbms_pkg::cfg_data_t  cfg_wdata
);

  dbms_pkg::cfg_t    cfg;

  // input stage
  logic              s1_valid;
  dbms_pkg::code_t   s1_code;

  // debounce and mode state
  dbms_pkg::code_t   last_code;
  dbms_pkg::code_t   last_code_next;
  dbms_pkg::count_t  stable_count;
  dbms_pkg::count_t  stable_count_next;
  dbms_pkg::count_t  dt_ext;
  dbms_pkg::count_t  dt_plus;
  logic              hit;
  dbms_pkg::mode_t   mode;
  dbms_pkg::mode_t   mode_act;
  dbms_pkg::mode_t   mode_next;
  dbms_pkg::code_t   acc_act;
  dbms_pkg::code_t   acc_next;

  // result register
  logic              out_valid;
  dbms_pkg::code_t   out_acc;
  dbms_pkg::mode_t   out_mode;

  logic              adv;   // result register free this cycle

  dbms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbms_menu u_menu (
    .code     (s1_code),
    .mode     (mode),
    .cfg      (cfg),
    .mode_act (mode_act),
    .acc      (acc_act)
  );

  assign adv          = !out_valid || result.ready;
  assign sample.ready = !s1_valid || adv;

  // Debounce: a change restarts the count; a repeat counts up. The press
  // fires once when the count equals debounce_ticks, then the count parks
  // at debounce_ticks + 1 until the code changes.
  assign dt_ext  = dbms_pkg::count_t'(cfg.debounce_ticks);
  assign dt_plus = dbms_pkg::count_t'(dt_ext + 1'b1);

  always_comb begin
    stable_count_next = stable_count;
    last_code_next    = last_code;
    hit               = 1'b0;
    if (s1_code == last_code) begin
      if (stable_count == dt_ext && s1_code != dbms_pkg::BtnNone) begin
        hit               = 1'b1;
        stable_count_next = dbms_pkg::count_t'(stable_count + 1'b1);
      end else if (stable_count < dt_plus) begin
        stable_count_next = dbms_pkg::count_t'(stable_count + 1'b1);
      end
    end else begin
      stable_count_next = '0;
      last_code_next    = s1_code;
    end
  end

  assign mode_next = hit ? mode_act : mode;
  assign acc_next  = hit ? acc_act  : dbms_pkg::BtnNone;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready) s1_code <= sample.button_code;
  end

  // state and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_code    <= '0;
      stable_count <= '0;
      mode         <= '0;
    end else if (adv) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        last_code    <= last_code_next;
        stable_count <= stable_count_next;
        mode         <= mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_acc  <= acc_next;
      out_mode <= mode_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.accepted_press = out_acc;
  assign result.mode_type      = out_mode.type_sel;
  assign result.range_select   = out_mode.range_sel;
  assign result.auto_range_on  = out_mode.auto_on;
  assign result.comms_on       = out_mode.comms_on;

  // type index stays inside the menu
  a_type_bound: assert property (@(posedge clk) disable iff (rst)
    mode.type_sel <= dbms_pkg::TypeTop)
    else $error("mode type out of range");

  // debounce count parks at most at the largest debounce length plus one
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stable_count <= dbms_pkg::count_t'(8))
    else $error("debounce count overran");

  // range index only moves on an accepted range press
  a_range_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && mode.range_sel != $past(mode.range_sel)) |->
    (out_acc == dbms_pkg::BtnRangeUp || out_acc == dbms_pkg::BtnRangeDown))
    else $error("range changed without range press");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> sample.ready)
    else $error("input stalled with empty result register");

endmodule

// File: tb/debounced_button_mode_selector_tb.sv
// Testbench for debounced_button_mode_selector: directed and random button
// sequences, each result item checked against an in-bench model of the menu.
// Depends on dbms_pkg, dbms_sample_if, dbms_result_if and the RTL.
`timescale 1ns / 100ps

module debounced_button_mode_selector_tb;

  // Receiver hold-off used to fill the block and back up the sample side
  localparam int HoldCycles = 200;
  // Items per random phase; six phases land near the item budget
  localparam int PhaseItems = 175;

  // One expected result item: the press acted on plus the mode after it
  typedef struct packed {
    dbms_pkg::code_t press;
    dbms_pkg::mode_t mode;
  } outcome_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  dbms_pkg::cfg_idx_t  cfg_index = dbms_pkg::RegDebounce;
  dbms_pkg::cfg_data_t cfg_wdata = '0;
  logic                ready_q   = 1'b0;

  dbms_sample_if in_ch();
  dbms_result_if out_ch();

  assign out_ch.ready = ready_q;

  debounced_button_mode_selector uut (
    .clk       (clk),
    .rst       (rst),
    .sample    (in_ch),
    .result    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Menu model: debounce state, mode state and its own copy of the config
  // ---------------------------------------------------------------------
  dbms_pkg::cfg_t   panel_cfg;
  dbms_pkg::mode_t  panel;
  dbms_pkg::code_t  btn_last;
  dbms_pkg::count_t btn_count;

  outcome_t pending_outcomes[$];

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned presses_seen    = 0;
  int unsigned samples_sent    = 0;
  int unsigned config_loads    = 0;

  // Knobs shared by the test tasks and the receiver
  logic            steady      = 1'b0;  // no idling on either side
  int unsigned     holds_asked = 0;
  int unsigned     holds_given = 0;
  int unsigned     hold_left   = 0;
  dbms_pkg::code_t last_sent   = dbms_pkg::BtnNone;

  // Advance the model by one sample. A repeat of the previous code counts
  // up; the repeat that lands on debounce_ticks fires the press once and the
  // count then parks one above until the code changes.
  function automatic outcome_t step_panel(dbms_pkg::code_t c);
    outcome_t         o;
    dbms_pkg::range_t top_range;
    o.press   = dbms_pkg::BtnNone;
    // types past the last max register have a range ceiling of zero
    top_range = (panel.type_sel < dbms_pkg::NumMaxRegs)
                ? panel_cfg.max_range[panel.type_sel] : dbms_pkg::range_t'(0);
    if (c != btn_last) begin
      btn_last  = c;
      btn_count = '0;
    end else if (btn_count == dbms_pkg::count_t'(panel_cfg.debounce_ticks) &&
                 c != dbms_pkg::BtnNone) begin
      btn_count = btn_count + 1'b1;
      o.press   = c;
      case (c)
        dbms_pkg::BtnTypeUp: begin
          panel.type_sel = (panel.type_sel >= dbms_pkg::TypeTop) ? dbms_pkg::type_t'(0)
                           : dbms_pkg::type_t'(panel.type_sel + 1'b1);
        end
        dbms_pkg::BtnTypeDown: begin
          panel.type_sel = (panel.type_sel == dbms_pkg::type_t'(0) ||
                            panel.type_sel > dbms_pkg::TypeTop)
                           ? dbms_pkg::TypeTop : dbms_pkg::type_t'(panel.type_sel - 1'b1);
        end
        // range steps are swallowed under auto-range but still count as a press;
        // an index above the ceiling wraps to zero going up, decrements going down
        dbms_pkg::BtnRangeUp: begin
          if (!panel.auto_on)
            panel.range_sel = (panel.range_sel >= top_range) ? dbms_pkg::range_t'(0)
                              : dbms_pkg::range_t'(panel.range_sel + 1'b1);
        end
        dbms_pkg::BtnRangeDown: begin
          if (!panel.auto_on)
            panel.range_sel = (panel.range_sel == dbms_pkg::range_t'(0)) ? top_range
                              : dbms_pkg::range_t'(panel.range_sel - 1'b1);
        end
        dbms_pkg::BtnAuto:  panel.auto_on  = ~panel.auto_on;
        dbms_pkg::BtnComms: panel.comms_on = ~panel.comms_on;
        default:            o.press = dbms_pkg::BtnNone;
      endcase
    end else if (btn_count < dbms_pkg::count_t'(panel_cfg.debounce_ticks) + 1) begin
      btn_count = btn_count + 1'b1;
    end
    o.mode = panel;
    return o;
  endfunction

  function automatic dbms_pkg::cfg_t make_cfg(dbms_pkg::cfg_data_t db,
                                              dbms_pkg::range_t v, dbms_pkg::range_t i,
                                              dbms_pkg::range_t r, dbms_pkg::range_t f,
                                              dbms_pkg::range_t c);
    dbms_pkg::cfg_t k;
    k.debounce_ticks = db;
    k.max_range      = {c, f, r, i, v};
    return k;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard: check the result item first, then queue the prediction for
  // a sample taken on this edge, whose result is still in the pipeline.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result item arrived with nothing pending");
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("accepted_press", int'(want.press), int'(out_ch.accepted_press));
          check_field("mode_type", int'(want.mode.type_sel), int'(out_ch.mode_type));
          check_field("range_select", int'(want.mode.range_sel),
                      int'(out_ch.range_select));
          check_field("auto_range_on", int'(want.mode.auto_on),
                      int'(out_ch.auto_range_on));
          check_field("comms_on", int'(want.mode.comms_on), int'(out_ch.comms_on));
          results_checked++;
          if (want.press != dbms_pkg::BtnNone) presses_seen++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_outcomes.push_back(step_panel(in_ch.button_code));
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls (about 31 percent of the time), none while steady,
  // and a long counted hold-off on request.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      ready_q <= 1'b0;
    end else if (holds_asked != holds_given) begin
      holds_given <= holds_asked;
      hold_left   <= HoldCycles;
      ready_q     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      ready_q   <= 1'b0;
    end else begin
      ready_q <= steady || ($urandom_range(99) >= 31);
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one sample and wait until it is taken. Valid stays high on return
  // so back-to-back items drop it only for a random idle; callers that pause lower it.
  task automatic send_sample(input dbms_pkg::code_t c);
    if (!steady && $urandom_range(99) < 31) begin
      in_ch.valid       <= 1'b0;
      in_ch.button_code <= dbms_pkg::code_t'($urandom_range(0, 7));  // junk while idle
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.button_code <= c;
    last_sent = c;
    samples_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // A clean press: held just long enough to be acted on (the change plus
  // debounce_ticks + 1 repeats). A repeat of the same button needs a release
  // in between.
  task automatic tap(input dbms_pkg::code_t c);
    if (c == last_sent) send_sample(dbms_pkg::BtnNone);
    repeat (int'(panel_cfg.debounce_ticks) + 2) send_sample(c);
  endtask

  // Stop offering and wait until every expected result is in, plus a little margin.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all six registers back to back with the block idle.
  task automatic load_config(input dbms_pkg::cfg_t c);
    drain_results();
    for (int r = int'(dbms_pkg::RegDebounce); r <= int'(dbms_pkg::RegMaxCapacitance);
         r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= dbms_pkg::cfg_idx_t'(r);
      if (r == int'(dbms_pkg::RegDebounce))
        cfg_wdata <= c.debounce_ticks;
      else
        cfg_wdata <= c.max_range[r - int'(dbms_pkg::RegMaxVoltage)];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    panel_cfg = c;
    config_loads++;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset config: debounce of 3, voltage ceiling 5; one range step up.
  task automatic test_reset_defaults();
    tap(dbms_pkg::BtnRangeUp);
  endtask

  // Type index wraps both ways.
  task automatic test_type_wrap();
    load_config(make_cfg(dbms_pkg::cfg_data_t'(1), dbms_pkg::range_t'(1),
                         dbms_pkg::range_t'(7), dbms_pkg::range_t'(0),
                         dbms_pkg::range_t'(0), dbms_pkg::range_t'(2)));
    tap(dbms_pkg::BtnTypeDown);   // 0 -> top
    tap(dbms_pkg::BtnTypeUp);     // top -> 0
  endtask

  // Range wrap at the ceiling, type change keeping the index, and an index
  // stranded above a smaller ceiling (down decrements, up wraps to zero).
  task automatic test_range_steps();
    tap(dbms_pkg::BtnRangeUp);    // at ceiling 1 -> 0
    tap(dbms_pkg::BtnRangeDown);  // 0 -> ceiling
    tap(dbms_pkg::BtnTypeUp);     // current type, index kept
    tap(dbms_pkg::BtnRangeUp);    // 1 -> 2 under ceiling 7
    tap(dbms_pkg::BtnTypeUp);     // resistance, ceiling 0, index 2 stranded
    tap(dbms_pkg::BtnRangeDown);  // 2 -> 1
    tap(dbms_pkg::BtnRangeUp);    // above ceiling -> 0
  endtask

  // Range step ignored under auto-range; both flags toggle.
  task automatic test_auto_and_comms();
    tap(dbms_pkg::BtnAuto);
    tap(dbms_pkg::BtnRangeUp);
    tap(dbms_pkg::BtnAuto);
    tap(dbms_pkg::BtnComms);
  endtask

  // Receiver holds off while the sender keeps offering, so the block fills
  // and stalls its input; then the sender waits for everything to drain.
  task automatic test_backpressure();
    drain_results();
    holds_asked <= holds_asked + 1;
    repeat (20) tap(dbms_pkg::code_t'($urandom_range(1, 6)));
    drain_results();
  endtask

  // Random phases over several settings, extremes first. Mostly clean
  // presses with random buttons and hold lengths, the rest bounce (with the
  // unused code mixed in), short holds and idle stretches. One phase runs
  // with no idling at all.
  task automatic test_random_presses();
    int unsigned     stop_at;
    int unsigned     pick;
    int unsigned     db;
    dbms_pkg::code_t c;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_config(make_cfg(dbms_pkg::cfg_data_t'(7), dbms_pkg::range_t'(7),
                                dbms_pkg::range_t'(7), dbms_pkg::range_t'(7),
                                dbms_pkg::range_t'(7), dbms_pkg::range_t'(7)));
        1: load_config(make_cfg(dbms_pkg::cfg_data_t'(1), dbms_pkg::range_t'(0),
                                dbms_pkg::range_t'(0), dbms_pkg::range_t'(0),
                                dbms_pkg::range_t'(0), dbms_pkg::range_t'(0)));
        default: load_config(make_cfg(dbms_pkg::cfg_data_t'($urandom_range(1, 7)),
                                      dbms_pkg::range_t'($urandom_range(0, 7)),
                                      dbms_pkg::range_t'($urandom_range(0, 7)),
                                      dbms_pkg::range_t'($urandom_range(0, 7)),
                                      dbms_pkg::range_t'($urandom_range(0, 7)),
                                      dbms_pkg::range_t'($urandom_range(0, 7))));
      endcase
      steady <= (ph == 3);
      db      = int'(panel_cfg.debounce_ticks);
      stop_at = samples_sent + PhaseItems;
      while (samples_sent < stop_at) begin
        pick = $urandom_range(99);
        c    = dbms_pkg::code_t'($urandom_range(1, 6));
        if (pick < 70) begin
          // clean press, sometimes held past acceptance, then at times a release
          repeat (db + 2 + $urandom_range(0, 3)) send_sample(c);
          repeat ($urandom_range(0, 2)) send_sample(dbms_pkg::BtnNone);
        end else if (pick < 85) begin
          // contact bounce
          repeat ($urandom_range(1, 6))
            send_sample(dbms_pkg::code_t'($urandom_range(0, 7)));
        end else if (pick < 95) begin
          // held too briefly after a change
          repeat ($urandom_range(1, db)) send_sample(c);
        end else begin
          repeat ($urandom_range(1, 5)) send_sample(dbms_pkg::BtnNone);
        end
      end
      steady <= 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.button_code <= dbms_pkg::BtnNone;
    panel_cfg.debounce_ticks = dbms_pkg::DebounceReset;
    panel_cfg.max_range      = {dbms_pkg::MaxCapacitanceReset, dbms_pkg::MaxFrequencyReset,
                                dbms_pkg::MaxResistanceReset, dbms_pkg::MaxCurrentReset,
                                dbms_pkg::MaxVoltageReset};
    panel     = '0;
    btn_last  = dbms_pkg::BtnNone;
    btn_count = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_type_wrap();
    test_range_steps();
    test_auto_and_comms();
    test_backpressure();
    test_random_presses();

    drain_results();
    repeat (10) @(posedge clk);

    $display("Checked %0d result items from %0d samples: %0d presses acted on,",
             results_checked, samples_sent, presses_seen);
    $display("over %0d config settings incl. extremes, with stalls and a long hold-off.",
             config_loads);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #(4_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
sv/dbms_pkg.sv
sv/dbms_sample_if.sv
sv/dbms_result_if.sv
sv/dbms_cfg_regs.sv
sv/dbms_menu.sv
sv/debounced_button_mode_selector.sv
tb/debounced_button_mode_selector_tb.sv
